// File: design/ps2sc_pkg.sv
// Shared types, prefix codes and the set 2 key lookup for the scan code decoder.
package ps2sc_pkg;

    localparam logic [7:0] BREAK_PREFIX    = 8'hF0;
    localparam logic [7:0] EXTENDED_PREFIX = 8'hE0;
    localparam logic [6:0] NO_KEY          = 7'h00;

    // One decode outcome per transfer.
    typedef struct packed {
        logic       hit;
        logic [6:0] ascii_char;
    } t_result;

    // Set 2 make code to lower-case ASCII; NO_KEY when the code is not mapped.
    function automatic logic [6:0] decode_key(input logic [7:0] code);
        logic [6:0] ch;
        unique case (code)
            8'h16:   ch = 7'h31; // 1
            8'h1E:   ch = 7'h32; // 2
            8'h26:   ch = 7'h33; // 3
            8'h25:   ch = 7'h34; // 4
            8'h2E:   ch = 7'h35; // 5
            8'h36:   ch = 7'h36; // 6
            8'h3D:   ch = 7'h37; // 7
            8'h3E:   ch = 7'h38; // 8
            8'h46:   ch = 7'h39; // 9
            8'h45:   ch = 7'h30; // 0
            8'h15:   ch = 7'h71; // q
            8'h1D:   ch = 7'h77; // w
            8'h24:   ch = 7'h65; // e
            8'h2D:   ch = 7'h72; // r
            8'h2C:   ch = 7'h74; // t
            8'h35:   ch = 7'h79; // y
            8'h3C:   ch = 7'h75; // u
            8'h43:   ch = 7'h69; // i
            8'h44:   ch = 7'h6F; // o
            8'h4D:   ch = 7'h70; // p
            8'h1C:   ch = 7'h61; // a
            8'h1B:   ch = 7'h73; // s
            8'h23:   ch = 7'h64; // d
            8'h2B:   ch = 7'h66; // f
            8'h34:   ch = 7'h67; // g
            8'h33:   ch = 7'h68; // h
            8'h3B:   ch = 7'h6A; // j
            8'h42:   ch = 7'h6B; // k
            8'h4B:   ch = 7'h6C; // l
            8'h1A:   ch = 7'h7A; // z
            8'h22:   ch = 7'h78; // x
            8'h21:   ch = 7'h63; // c
            8'h2A:   ch = 7'h76; // v
            8'h32:   ch = 7'h62; // b
            8'h31:   ch = 7'h6E; // n
            8'h3A:   ch = 7'h6D; // m
            default: ch = NO_KEY;
        endcase
        return ch;
    endfunction

endpackage

// File: design/ps2sc_decoder.sv
// Release/held-key tracking and key decode for one scan code per step.
module ps2sc_decoder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_code,
    output ps2sc_pkg::t_result o_result
);

    logic       r_release_pending;
    logic       r_key_held;
    logic       n_release_pending;
    logic       n_key_held;
    logic [6:0] key_char;

    assign key_char = ps2sc_pkg::decode_key(i_code);

    always_comb begin
        n_release_pending   = r_release_pending;
        n_key_held          = r_key_held;
        o_result.hit        = 1'b0;
        o_result.ascii_char = key_char;
        priority if (i_code == ps2sc_pkg::BREAK_PREFIX) begin
            n_release_pending = 1'b1;
            n_key_held        = 1'b0;
        end else if ((r_key_held && !r_release_pending) ||
                     (i_code == ps2sc_pkg::EXTENDED_PREFIX)) begin
            // held key or extended prefix: nothing changes
        end else begin
            if (!r_release_pending && (key_char != ps2sc_pkg::NO_KEY)) begin
                o_result.hit = 1'b1;
                n_key_held   = 1'b1;
            end
            n_release_pending = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_release_pending <= 1'b0;
            r_key_held        <= 1'b0;
        end else if (i_step) begin
            r_release_pending <= n_release_pending;
            r_key_held        <= n_key_held;
        end
    end

    a_break_sets_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (i_code == ps2sc_pkg::BREAK_PREFIX)) |=>
            (r_release_pending && !r_key_held))
        else $error("break prefix did not arm release");

    a_hit_needs_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.hit |-> (!r_release_pending && !r_key_held))
        else $error("key decoded while held or release pending");

    a_hit_holds_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_result.hit) |=> r_key_held)
        else $error("decoded key not marked held");

endmodule

// File: design/ps2_scan_code_to_ascii_top.sv
// Top level: PS/2 set 2 scan code to ASCII decoder with valid/ready channels.
// Each scan code byte transfer yields at most one ASCII character ('0'-'9',
// 'a'-'z') for make codes of the 36 mapped keys. 0xF0 marks a release and the
// code after it is dropped; 0xE0 is ignored; once a key has produced a
// character, repeats and other make codes give nothing until a release. One
// byte is taken per clock while nothing stalls: the byte lands in an input
// register, the decode is a single table lookup plus two state flags, and the
// character lands in an output register; throughput is one transfer per cycle
// while i_ready stays high. The input register advances whenever the output
// register is empty or being drained. While a character waits with i_ready
// low, a byte already in the input register holds and o_ready drops, so at
// most two bytes are in flight; o_ready depends on i_ready combinationally.
module ps2_scan_code_to_ascii_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_scan_code,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [6:0] o_ascii_char
);

    logic                r_s1_valid;
    logic [7:0]          r_s1_code;
    logic                r_out_valid;
    logic [6:0]          r_out_char;
    logic                n_s1_valid;
    logic                n_out_valid;
    logic                s1_go;
    logic                in_xfer;
    ps2sc_pkg::t_result  dec_result;

    // input stage moves on when the output slot is free or emptying
    assign s1_go   = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || s1_go;
    assign in_xfer = i_valid && o_ready;

    ps2sc_decoder u_decoder (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (s1_go),
        .i_code   (r_s1_code),
        .o_result (dec_result)
    );

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_xfer) begin
            n_s1_valid = 1'b1;
        end else if (s1_go) begin
            n_s1_valid = 1'b0;
        end

        n_out_valid = r_out_valid;
        if (s1_go) begin
            n_out_valid = dec_result.hit;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_code <= i_scan_code;
        end
        if (s1_go && dec_result.hit) begin
            r_out_char <= dec_result.ascii_char;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_ascii_char = r_out_char;

    a_char_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (((o_ascii_char >= 7'h30) && (o_ascii_char <= 7'h39)) ||
                     ((o_ascii_char >= 7'h61) && (o_ascii_char <= 7'h7A))))
        else $error("output character outside decoded set");

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_go) |=> (r_s1_valid && $stable(r_s1_code)))
        else $error("stalled input stage lost its byte");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_ascii_char)))
        else $error("stalled output changed before transfer");

endmodule
